FILE: hdl/form_urlencoded_decoder_core_assert.svh
// assertion macros for the form-urlencoded decoder checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef FORM_URLENCODED_DECODER_CORE_ASSERT_SVH
`define FORM_URLENCODED_DECODER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FUD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FUD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fud_pkg.sv
// shared types and constants for the form-urlencoded decoder
// no dependencies
package fud_pkg;

  // result kinds
  localparam logic [2:0] KIND_KEY    = 3'd0;
  localparam logic [2:0] KIND_VALUE  = 3'd1;
  localparam logic [2:0] KIND_DONE   = 3'd2;
  localparam logic [2:0] KIND_DROP   = 3'd3;
  localparam logic [2:0] KIND_BADHEX = 3'd4;

  // special characters
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } fud_result_t;

  // one queue entry holds all results of one input byte
  typedef struct packed {
    logic        second;
    fud_result_t res0;
    fud_result_t res1;
  } fud_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fud_qstat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } fud_hex_t;

  function automatic fud_hex_t hex_decode(input logic [7:0] c);
    fud_hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: hdl/form_urlencoded_decoder_core.sv
// top level of the form-urlencoded decoder: front, entry queue and back
// depends on fud_pkg, fud_front, fud_queue, fud_back
//
// usage
// - input channel: in_valid_i / in_stall_o carry one raw byte (in_byte_i) and
//   a stream end flag (stream_last_i); a transfer happens when valid is high
//   and stall is low at a rising edge
// - output channel: out_valid_o / out_stall_i carry one result: kind_o,
//   data_byte_o and run_last_o (set on the last result of an input byte)
// - each input byte yields zero, one or two results
// - a byte's results enter the queue at its transfer, then the output register
// - throughput: one byte per cycle while bytes average at most one result and
//   the output is not stalled; the back end drains one result per cycle, so a
//   byte with two results takes one output transfer for each of them
// - the front parses and updates the phase state the cycle a byte transfers
//   and writes one entry per byte that has results into a QueueDepth-entry
//   queue
// - in_stall_o rises only while that queue is full
// - a stalled output holds its result; the front keeps taking bytes until the
//   queue fills up
// - reset (rst_ni low, asynchronous) returns to key phase, clears the error
//   flag, empties the queue and drops the output register
module form_urlencoded_decoder_core #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       run_last_o
);
  import fud_pkg::*;

  logic       accept, push, pop;
  fud_entry_t entry, head;
  fud_qstat_t qstat;

  // stall only depends on queue occupancy
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  fud_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .stream_last_i (stream_last_i),
    .push_o        (push),
    .entry_o       (entry)
  );

  // bytes that produce no result never occupy a slot
  fud_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry),
    .pop_i   (pop),
    .rdata_o (head),
    .stat_o  (qstat)
  );

  fud_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

FILE: hdl/fud_front.sv
// front part: parses one raw byte a cycle and builds a queue entry
// depends on fud_pkg
module fud_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               stream_last_i,
  output logic               push_o,
  output fud_pkg::fud_entry_t entry_o
);
  import fud_pkg::*;

  typedef enum logic [5:0] {
    PH_KEY    = 6'b000001,
    PH_KEY_H1 = 6'b000010,
    PH_KEY_H2 = 6'b000100,
    PH_VAL    = 6'b001000,
    PH_VAL_H1 = 6'b010000,
    PH_VAL_H2 = 6'b100000
  } fud_phase_e;

  fud_phase_e  phase_q, phase_d, pn;
  logic [3:0]  nib_q, nib_d;
  logic        failed_q, failed_d;
  fud_hex_t    hx;
  logic        r0_v, end_v, bad, is_val;
  fud_result_t r0, endr;

  always_comb begin
    hx       = hex_decode(in_byte_i);
    pn       = phase_q;
    nib_d    = nib_q;
    r0_v     = 1'b0;
    r0       = '{kind: KIND_KEY, data: '0};
    end_v    = 1'b0;
    endr     = '{kind: KIND_DROP, data: '0};
    bad      = 1'b0;
    is_val   = 1'b0;
    phase_d  = phase_q;
    failed_d = failed_q;

    unique case (phase_q)
      PH_KEY_H1, PH_VAL_H1: begin
        if (!hx.ok) begin
          bad = 1'b1;
        end else begin
          nib_d = hx.val;
          pn    = (phase_q == PH_VAL_H1) ? PH_VAL_H2 : PH_KEY_H2;
        end
      end
      PH_KEY_H2, PH_VAL_H2: begin
        if (!hx.ok) begin
          bad = 1'b1;
        end else begin
          r0_v    = 1'b1;
          r0.kind = (phase_q == PH_VAL_H2) ? KIND_VALUE : KIND_KEY;
          r0.data = {nib_q, hx.val};
          pn      = (phase_q == PH_VAL_H2) ? PH_VAL : PH_KEY;
        end
      end
      default: begin
        // key or value phase; unused codes act as key
        is_val = (phase_q == PH_VAL);
        if (!is_val && in_byte_i == CH_EQ) begin
          pn = PH_VAL;
        end else if (is_val && (in_byte_i == CH_AMP || in_byte_i == CH_LF)) begin
          r0_v    = 1'b1;
          r0.kind = KIND_DONE;
          pn      = PH_KEY;
        end else if (in_byte_i == CH_PCT) begin
          pn = is_val ? PH_VAL_H1 : PH_KEY_H1;
        end else begin
          r0_v    = 1'b1;
          r0.kind = is_val ? KIND_VALUE : KIND_KEY;
          r0.data = (in_byte_i == CH_PLUS) ? CH_SPACE : in_byte_i;
        end
      end
    endcase

    if (failed_q) begin
      // swallow bytes until the stream ends
      r0_v  = 1'b0;
      nib_d = nib_q;
      if (stream_last_i) begin
        phase_d  = PH_KEY;
        nib_d    = '0;
        failed_d = 1'b0;
      end
    end else if (bad) begin
      r0_v     = 1'b1;
      r0       = '{kind: KIND_BADHEX, data: '0};
      phase_d  = PH_KEY;
      nib_d    = '0;
      failed_d = !stream_last_i;
    end else if (stream_last_i) begin
      end_v     = 1'b1;
      endr.kind = (pn == PH_VAL) ? KIND_DONE : KIND_DROP;
      phase_d   = PH_KEY;
      nib_d     = '0;
    end else begin
      phase_d = pn;
    end
  end

  assign push_o       = accept_i && (r0_v || end_v);
  assign entry_o.second = r0_v && end_v;
  assign entry_o.res0 = r0_v ? r0 : endr;
  assign entry_o.res1 = endr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_KEY;
      nib_q    <= '0;
      failed_q <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      nib_q    <= nib_d;
      failed_q <= failed_d;
    end
  end

endmodule

FILE: hdl/fud_queue.sv
// short entry queue between the parse front and the result back
// depends on fud_pkg
module fud_queue #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fud_pkg::fud_entry_t wdata_i,
  input  logic                pop_i,
  output fud_pkg::fud_entry_t rdata_o,
  output fud_pkg::fud_qstat_t stat_o
);
  import fud_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fud_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/fud_back.sv
// back part: walks the results of each queue entry into the output register
// depends on fud_pkg
module fud_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fud_pkg::fud_entry_t head_i,
  input  fud_pkg::fud_qstat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          kind_o,
  output logic [7:0]          data_byte_o,
  output logic                run_last_o
);
  import fud_pkg::*;

  logic        valid_q, sel_q, load;
  logic [2:0]  kind_q;
  logic [7:0]  data_q;
  logic        last_q;
  fud_result_t cur;

  assign load  = !stat_i.empty && (!valid_q || !out_stall_i);
  assign cur   = sel_q ? head_i.res1 : head_i.res0;
  assign pop_o = load && (sel_q || !head_i.second);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      sel_q   <= !sel_q && head_i.second;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= cur.kind;
      data_q <= cur.data;
      last_q <= sel_q || !head_i.second;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign data_byte_o = data_q;
  assign run_last_o  = last_q;

endmodule

FILE: hdl/fud_checker.sv
// port-level checks for the form-urlencoded decoder, bound to the top level
// depends on fud_pkg and form_urlencoded_decoder_core_assert.svh
`include "form_urlencoded_decoder_core_assert.svh"

module fud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       stream_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       run_last_o
);
  import fud_pkg::*;

  // a stalled input transfer holds until taken
  `FUD_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_byte_i) && $stable(stream_last_i), "stalled input changed")

  // a stalled result holds
  `FUD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o) && $stable(data_byte_o) && $stable(run_last_o), "stalled result changed")

  `FUD_ASSERT_IMPL(a_kind_range, out_valid_o, kind_o <= KIND_BADHEX, "result kind out of range")

  // only key and value bytes carry data
  `FUD_ASSERT_IMPL(a_data_zero, out_valid_o && (kind_o == KIND_DONE || kind_o == KIND_DROP || kind_o == KIND_BADHEX), data_byte_o == 8'h00, "control result with data")

  // drop and bad hex always close the results of their byte
  `FUD_ASSERT_IMPL(a_closing_last, out_valid_o && (kind_o == KIND_DROP || kind_o == KIND_BADHEX), run_last_o, "closing result without run_last")

endmodule

bind form_urlencoded_decoder_core fud_checker u_fud_checker (.*);

FILE: tb/sv/form_urlencoded_decoder_core_test.sv
// self-checking testbench for form_urlencoded_decoder_core: random byte streams
// against a cycle-free decoder prediction; depends on fud_pkg and the core rtl
module form_urlencoded_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fud_pkg::*;

  // run length guard, long receiver hold-off, drain wait and report limit
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 10;
  localparam int MaxReported = 10;

  // decoder phase as the prediction tracks it
  typedef enum logic [2:0] {
    ST_KEY    = 3'd0,
    ST_KEY_HI = 3'd1,
    ST_KEY_LO = 3'd2,
    ST_VAL    = 3'd3,
    ST_VAL_HI = 3'd4,
    ST_VAL_LO = 3'd5
  } dec_phase_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
    logic       run_last;
  } decoded_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte     = 8'h00;
  logic       stream_last = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       run_last;

  // bytes waiting to be offered, and decoded results waiting to come out
  raw_byte_t  raw_bytes[$];
  decoded_t   decoded_results[$];

  // prediction state
  dec_phase_e phase_q;
  logic [3:0] nibble_q;
  logic       failed_q;

  // idling percentages and hold-off request set by the sequencer, hold-off state
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_granted  = 0;
  int hold_left     = 0;

  int errors        = 0;
  int results_seen  = 0;
  int cycle_count   = 0;

  form_urlencoded_decoder_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_byte_i     (in_byte),
    .stream_last_i (stream_last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .kind_o        (kind),
    .data_byte_o   (data_byte),
    .run_last_o    (run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // {ok, value} of an ascii hex digit, ok low for anything else
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};  // 0-9
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};  // A-F
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};  // a-f
    return 5'h00;
  endfunction

  task automatic clear_decoder();
    phase_q  = ST_KEY;
    nibble_q = 4'h0;
    failed_q = 1'b0;
  endtask

  // decode one transferred byte and queue the results it causes
  task automatic decode_byte(input logic [7:0] c, input logic last);
    logic [2:0] res_kind[2];
    logic [7:0] res_data[2];
    int         n;
    dec_phase_e p;
    logic       bad;
    logic       is_val;
    logic [2:0] k;
    logic [4:0] h;
    n   = 0;
    p   = phase_q;
    bad = 1'b0;
    // a failed stream swallows everything up to its last byte
    if (failed_q) begin
      if (last) clear_decoder();
      return;
    end
    case (p)
      ST_KEY, ST_VAL: begin
        is_val = (p == ST_VAL);
        k      = is_val ? KIND_VALUE : KIND_KEY;
        if (!is_val && c == CH_EQ) begin
          p = ST_VAL;
        end else if (is_val && (c == CH_AMP || c == CH_LF)) begin
          res_kind[n] = KIND_DONE;
          res_data[n] = 8'h00;
          n++;
          p = ST_KEY;
        end else if (c == CH_PCT) begin
          p = is_val ? ST_VAL_HI : ST_KEY_HI;
        end else begin
          // plus decodes to space, separators in the wrong phase are data
          res_kind[n] = k;
          res_data[n] = (c == CH_PLUS) ? CH_SPACE : c;
          n++;
        end
      end
      default: begin
        h = hex_nibble(c);
        if (!h[4]) begin
          bad = 1'b1;
        end else if (p == ST_KEY_HI || p == ST_VAL_HI) begin
          nibble_q = h[3:0];
          p = (p == ST_VAL_HI) ? ST_VAL_LO : ST_KEY_LO;
        end else begin
          res_kind[n] = (p == ST_VAL_LO) ? KIND_VALUE : KIND_KEY;
          res_data[n] = {nibble_q, h[3:0]};
          n++;
          p = (p == ST_VAL_LO) ? ST_VAL : ST_KEY;
        end
      end
    endcase
    if (bad) begin
      // bad hex: report it and drop the pair silently
      res_kind[n] = KIND_BADHEX;
      res_data[n] = 8'h00;
      n++;
      clear_decoder();
      failed_q = !last;
    end else if (last) begin
      // stream end completes a pair in the value phase, drops anything else
      res_kind[n] = (p == ST_VAL) ? KIND_DONE : KIND_DROP;
      res_data[n] = 8'h00;
      n++;
      clear_decoder();
    end else begin
      phase_q = p;
    end
    for (int i = 0; i < n; i++) begin
      decoded_results.push_back('{res_kind[i], res_data[i], i == n - 1});
    end
  endtask

  task automatic log_error(input string msg);
    errors++;
    if (errors <= MaxReported) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: offers queued bytes, holds them while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_inputs
    raw_byte_t nxt;
    if (rst_n) begin
      // a new byte may only be offered once the current one has transferred
      if (!in_valid || !in_stall) begin
        if (raw_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = raw_bytes.pop_front();
          in_valid    <= 1'b1;
          in_byte     <= nxt.data;
          stream_last <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stall: random idling, or a long counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_granted != hold_asked) begin
        hold_granted <= hold_granted + 1;
        hold_left    <= HoldCycles;
        out_stall    <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each input transfer, check each output transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    decoded_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) decode_byte(in_byte, stream_last);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (decoded_results.size() == 0) begin
          log_error($sformatf("result %0d unexpected: kind %0d data %02h last %0d",
                              results_seen, kind, data_byte, run_last));
        end else begin
          want = decoded_results.pop_front();
          if (kind !== want.kind || data_byte !== want.data || run_last !== want.run_last) begin
            log_error($sformatf(
              "result %0d mismatch: kind %0d/%0d data %02h/%02h last %0d/%0d (exp/got)",
              results_seen, want.kind, kind, want.data, data_byte, want.run_last,
              run_last));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] c, input logic last);
    raw_bytes.push_back('{c, last});
  endtask

  // ascii text, last flag on its final character only
  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_hex_digit();
    logic [7:0] v;
    v = 8'($urandom_range(15));
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    logic [4:0] h;
    do begin
      c = 8'($urandom_range(255));
      h = hex_nibble(c);
    end while (h[4]);
    return c;
  endfunction

  // a data byte that does not switch phase or open an escape
  function automatic logic [7:0] rand_plain(input logic is_val);
    logic [7:0] c;
    if ($urandom_range(9) == 0) return CH_PLUS;
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_PCT || (!is_val && c == CH_EQ) ||
               (is_val && (c == CH_AMP || c == CH_LF)));
    return c;
  endfunction

  // key or value text with a mix of plain bytes and escapes
  task automatic add_field(input logic is_val);
    int len;
    len = $urandom_range(0, 6);
    repeat (len) begin
      if ($urandom_range(4) == 0) begin
        push_byte(CH_PCT, 1'b0);
        push_byte(rand_hex_digit(), 1'b0);
        push_byte(rand_hex_digit(), 1'b0);
      end else begin
        push_byte(rand_plain(is_val), 1'b0);
      end
    end
  endtask

  // one stream: mostly well-formed pairs, some broken or pure noise
  task automatic add_stream();
    int roll;
    int npairs;
    int start;
    roll  = $urandom_range(99);
    start = raw_bytes.size();
    if (roll < 12) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      npairs = $urandom_range(1, 4);
      for (int p = 0; p < npairs; p++) begin
        add_field(1'b0);
        if ($urandom_range(9) != 0) begin
          push_byte(CH_EQ, 1'b0);
          add_field(1'b1);
          if (p != npairs - 1 || $urandom_range(3) == 0)
            push_byte($urandom_range(1) ? CH_AMP : CH_LF, 1'b0);
        end
      end
      if (roll < 30) begin
        // bad escape, then junk that the failed stream must ignore
        push_byte(CH_PCT, 1'b0);
        if ($urandom_range(1)) push_byte(rand_hex_digit(), 1'b0);
        push_byte(rand_nonhex(), 1'b0);
        repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(255)), 1'b0);
      end else if (roll < 38) begin
        // stream cut inside an escape
        push_byte(CH_PCT, 1'b0);
        if ($urandom_range(1)) push_byte(rand_hex_digit(), 1'b0);
      end
    end
    if (raw_bytes.size() == start) push_byte(rand_plain(1'b0), 1'b0);
    raw_bytes[raw_bytes.size() - 1].last = 1'b1;
  endtask

  task automatic add_directed();
    push_text("k+=%41+&", 1'b0);   // plus in key and value, escape, ampersand
    push_text("%fF=%00\n", 1'b0);  // mixed-case escape, zero byte, newline end
    push_text("&=b", 1'b1);        // ampersand as key data, stream end in value
    push_byte(8'h00, 1'b0);        // raw byte extremes in the key
    push_byte(8'hFF, 1'b1);        // stream end in the key drops the pair
    push_text("%gzq", 1'b1);       // bad hex mid-stream, rest ignored
    push_text("=%4", 1'b1);        // stream end inside a value escape
    push_text("%Z", 1'b1);         // bad hex on the last byte
  endtask

  // wait for every byte to transfer and every result to come out
  task automatic wait_drained();
    while (raw_bytes.size() != 0 || in_valid || decoded_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
                           input logic directed, input logic long_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (long_hold) hold_asked++;
    if (directed) add_directed();
    while (raw_bytes.size() < n_items) add_stream();
    wait_drained();
  endtask

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // sequencer: reset, three idling regimes, final verdict
  initial begin
    clear_decoder();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // sender idles lightly, receiver heavily
    run_phase(22, 62, 430, 1'b1, 1'b0);
    // the other way round
    run_phase(62, 22, 430, 1'b0, 1'b0);
    // no idling, with a long receiver hold-off so the input backs up
    run_phase(0, 0, 440, 1'b0, 1'b1);
    if (errors == 0 && decoded_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
